@@ src/srct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srct_pkg
// Types, register indexes and helpers for the scaled rectangle clip transform.
// ----------------------------------------------------------------------------
package srct_pkg;

  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 264;
  localparam int unsigned OutDataW  = 264;

  localparam logic [CfgAddrW-1:0] RegScale   = 3'd0;
  localparam logic [CfgAddrW-1:0] RegOriginH = 3'd1;
  localparam logic [CfgAddrW-1:0] RegOriginV = 3'd2;
  localparam logic [CfgAddrW-1:0] RegViewL   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegViewT   = 3'd4;
  localparam logic [CfgAddrW-1:0] RegViewW   = 3'd5;
  localparam logic [CfgAddrW-1:0] RegViewH   = 3'd6;

  localparam logic [7:0] StrokeMax = 8'd255;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [48:0] prod_t;
  typedef logic signed [49:0] wide_t;
  typedef logic signed [33:0] edge_t;

  // products of the scale stage
  typedef struct packed {
    prod_t       px;
    prod_t       py;
    prod_t       sw;
    prod_t       sh;
    prod_t       ox;
    prod_t       oy;
    prod_t       ow;
    prod_t       oh;
    logic [23:0] stroke;
    logic        own;
  } s1_t;

  // offset and range-checked values
  typedef struct packed {
    coord_t     px;
    coord_t     py;
    coord_t     sw;
    coord_t     sh;
    coord_t     ox;
    coord_t     oy;
    coord_t     ow;
    coord_t     oh;
    logic [7:0] stroke;
    logic       own;
    logic       fail;
  } s2_t;

  // clip edges after intersection
  typedef struct packed {
    coord_t     px;
    coord_t     py;
    coord_t     sw;
    coord_t     sh;
    logic [7:0] stroke;
    coord_t     cx;
    coord_t     cy;
    edge_t      right;
    edge_t      bottom;
    logic       fail;
  } s3_t;

  // result item
  typedef struct packed {
    logic        ok;
    coord_t      px;
    coord_t      py;
    coord_t      sw;
    coord_t      sh;
    logic [7:0]  stroke;
    coord_t      cx;
    coord_t      cy;
    logic [31:0] cw;
    logic [31:0] ch;
  } s4_t;

  function automatic prod_t scale_mul(input coord_t v, input logic [15:0] s);
    prod_t a;
    prod_t b;
    a = prod_t'(v);
    b = prod_t'({1'b0, s});
    return a * b;
  endfunction

  function automatic logic fits32(input wide_t v);
    return (v[49:31] == '0) || (v[49:31] == '1);
  endfunction

endpackage

@@ src/scaled_rect_clip_transform_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_rect_clip_transform_core
// Scales and offsets an overlay rectangle and intersects its clip with the view.
// ----------------------------------------------------------------------------
// Four register stages: scale multiply, origin add with range check, clip edge
// min/max, clip size subtract into the output register. One transfer is taken
// every cycle while the output accepts; each stage holds under back-pressure
// and fills its own bubble, so an item is taken while a result waits in the
// output register. Configuration is read straight from the registers and must
// only change while the pipeline is empty. A failed item comes out with tuser
// low and all data bits zero.
module scaled_rect_clip_transform_core
  import srct_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pos_x, pos_y, size_w, size_h, stroke_width, own_clip_x, own_clip_y,
  // own_clip_w, own_clip_h
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_pos_x, out_pos_y, out_size_w, out_size_h, out_stroke, out_clip_x,
  // out_clip_y, out_clip_w, out_clip_h
  output logic [OutDataW-1:0] m_axis_tdata,
  // ok
  output logic                m_axis_tuser
);

  logic [15:0] scale_q;
  coord_t      origin_h_q;
  coord_t      origin_v_q;
  coord_t      view_l_q;
  coord_t      view_t_q;
  logic [30:0] view_w_q;
  logic [30:0] view_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= 16'd1;
      origin_h_q <= '0;
      origin_v_q <= '0;
      view_l_q   <= '0;
      view_t_q   <= '0;
      view_w_q   <= '0;
      view_h_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegScale:   scale_q    <= cfg_data_i[15:0];
        RegOriginH: origin_h_q <= cfg_data_i;
        RegOriginV: origin_v_q <= cfg_data_i;
        RegViewL:   view_l_q   <= cfg_data_i;
        RegViewT:   view_t_q   <= cfg_data_i;
        RegViewW:   view_w_q   <= cfg_data_i[30:0];
        RegViewH:   view_h_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4          = !v4_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: scale
  coord_t in_px, in_py, in_sw, in_sh, in_ox, in_oy, in_ow, in_oh;
  logic [7:0] in_stroke;
  s1_t s1_d, s1_q;

  assign in_px     = s_axis_tdata[31:0];
  assign in_py     = s_axis_tdata[63:32];
  assign in_sw     = s_axis_tdata[95:64];
  assign in_sh     = s_axis_tdata[127:96];
  assign in_stroke = s_axis_tdata[135:128];
  assign in_ox     = s_axis_tdata[167:136];
  assign in_oy     = s_axis_tdata[199:168];
  assign in_ow     = s_axis_tdata[231:200];
  assign in_oh     = s_axis_tdata[263:232];

  always_comb begin
    s1_d.px     = scale_mul(in_px, scale_q);
    s1_d.py     = scale_mul(in_py, scale_q);
    s1_d.sw     = scale_mul(in_sw, scale_q);
    s1_d.sh     = scale_mul(in_sh, scale_q);
    s1_d.ox     = scale_mul(in_ox, scale_q);
    s1_d.oy     = scale_mul(in_oy, scale_q);
    s1_d.ow     = scale_mul(in_ow, scale_q);
    s1_d.oh     = scale_mul(in_oh, scale_q);
    s1_d.stroke = {16'd0, in_stroke} * {8'd0, scale_q};
    s1_d.own    = (in_ow > 0) && (in_oh > 0);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
  end

  // stage 2: origin and range check
  wide_t w_px, w_py, w_sw, w_sh, w_ox, w_oy, w_ow, w_oh;
  s2_t   s2_d, s2_q;

  always_comb begin
    w_px = wide_t'(s1_q.px) + wide_t'(origin_h_q);
    w_py = wide_t'(s1_q.py) + wide_t'(origin_v_q);
    w_sw = wide_t'(s1_q.sw);
    w_sh = wide_t'(s1_q.sh);
    w_ox = wide_t'(s1_q.ox) + wide_t'(origin_h_q);
    w_oy = wide_t'(s1_q.oy) + wide_t'(origin_v_q);
    w_ow = wide_t'(s1_q.ow);
    w_oh = wide_t'(s1_q.oh);

    s2_d.px     = w_px[31:0];
    s2_d.py     = w_py[31:0];
    s2_d.sw     = w_sw[31:0];
    s2_d.sh     = w_sh[31:0];
    s2_d.ox     = w_ox[31:0];
    s2_d.oy     = w_oy[31:0];
    s2_d.ow     = w_ow[31:0];
    s2_d.oh     = w_oh[31:0];
    s2_d.stroke = (|s1_q.stroke[23:8]) ? StrokeMax : s1_q.stroke[7:0];
    s2_d.own    = s1_q.own;
    s2_d.fail   = (scale_q == '0) || (view_w_q == '0) || (view_h_q == '0) ||
                  !fits32(w_px) || !fits32(w_py) || !fits32(w_sw) || !fits32(w_sh) ||
                  (s1_q.own && (!fits32(w_ox) || !fits32(w_oy) ||
                                !fits32(w_ow) || !fits32(w_oh)));
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) s2_q <= s2_d;
  end

  // stage 3: clip edges
  edge_t view_r, view_b, own_r, own_b;
  s3_t   s3_d, s3_q;

  always_comb begin
    view_r = edge_t'(view_l_q) + edge_t'({1'b0, view_w_q});
    view_b = edge_t'(view_t_q) + edge_t'({1'b0, view_h_q});
    own_r  = edge_t'(s2_q.ox) + edge_t'(s2_q.ow);
    own_b  = edge_t'(s2_q.oy) + edge_t'(s2_q.oh);

    s3_d.px     = s2_q.px;
    s3_d.py     = s2_q.py;
    s3_d.sw     = s2_q.sw;
    s3_d.sh     = s2_q.sh;
    s3_d.stroke = s2_q.stroke;
    s3_d.fail   = s2_q.fail;
    s3_d.cx     = view_l_q;
    s3_d.cy     = view_t_q;
    s3_d.right  = view_r;
    s3_d.bottom = view_b;
    if (s2_q.own) begin
      if (s2_q.ox > view_l_q) s3_d.cx = s2_q.ox;
      if (s2_q.oy > view_t_q) s3_d.cy = s2_q.oy;
      if (own_r < view_r)     s3_d.right = own_r;
      if (own_b < view_b)     s3_d.bottom = own_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) s3_q <= s3_d;
  end

  // stage 4: clip size and result
  edge_t cw, ch;
  s4_t   s4_d, s4_q;

  always_comb begin
    cw = s3_q.right - edge_t'(s3_q.cx);
    ch = s3_q.bottom - edge_t'(s3_q.cy);
    s4_d = '0;
    if (!s3_q.fail && (cw > 0) && (ch > 0)) begin
      s4_d.ok     = 1'b1;
      s4_d.px     = s3_q.px;
      s4_d.py     = s3_q.py;
      s4_d.sw     = s3_q.sw;
      s4_d.sh     = s3_q.sh;
      s4_d.stroke = s3_q.stroke;
      s4_d.cx     = s3_q.cx;
      s4_d.cy     = s3_q.cy;
      s4_d.cw     = cw[31:0];
      s4_d.ch     = ch[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) s4_q <= s4_d;
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tuser  = s4_q.ok;
  assign m_axis_tdata  = {s4_q.ch, s4_q.cw, s4_q.cy, s4_q.cx, s4_q.stroke,
                          s4_q.sh, s4_q.sw, s4_q.py, s4_q.px};

endmodule

@@ sim/scaled_rect_clip_transform_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_rect_clip_transform_core_tb
// Self-checking bench for the scaled rectangle clip transform core.
// ----------------------------------------------------------------------------
// Rectangles go in over the input stream and are scaled, offset and clipped
// by a model inside the bench. Every output transfer is checked field by
// field against the oldest outstanding prediction. A directed part covers the
// range limits, stroke saturation, own clip handling and empty views. Random
// register settings and rectangles follow, with idle cycles on both sides, a
// stretch at full rate and a long output stall that backs up the pipeline.
module scaled_rect_clip_transform_core_tb;
  import srct_pkg::*;

  localparam logic [CfgAddrW-1:0] RegUnused  = 3'd7;
  localparam longint              CoordMin   = -64'sd2147483648;
  localparam longint              CoordMax   = 64'sd2147483647;
  localparam int                  StallLimit = 4000;
  localparam int                  DrainWait  = 8;

  // fields from the top down, so pos_x lands in the lowest bits
  typedef struct packed {
    logic signed [31:0] clip_h;
    logic signed [31:0] clip_w;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_x;
    logic [7:0]         stroke;
    logic signed [31:0] size_h;
    logic signed [31:0] size_w;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } rect_t;

  typedef struct packed {
    logic               ok;
    logic [31:0]        clip_h;
    logic [31:0]        clip_w;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_x;
    logic [7:0]         stroke;
    logic signed [31:0] size_h;
    logic signed [31:0] size_w;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } outcome_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // pos_x, pos_y, size_w, size_h, stroke_width, own_clip_x, own_clip_y,
  // own_clip_w, own_clip_h
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // out_pos_x, out_pos_y, out_size_w, out_size_h, out_stroke, out_clip_x,
  // out_clip_y, out_clip_w, out_clip_h
  logic [OutDataW-1:0] m_axis_tdata;
  // ok
  logic                m_axis_tuser;

  // register copies
  logic [15:0]        scale_r;
  logic signed [31:0] origin_x_r;
  logic signed [31:0] origin_y_r;
  logic signed [31:0] view_x_r;
  logic signed [31:0] view_y_r;
  logic [30:0]        view_w_r;
  logic [30:0]        view_h_r;

  outcome_t pending_outcomes[$];
  int       fail_cnt     = 0;
  int       idle_cycles  = 0;
  int       rx_stall_req = 0;
  bit       tx_idle_en   = 1'b1;
  bit       rx_idle_en   = 1'b1;

  scaled_rect_clip_transform_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit in_coord_range(input longint v);
    return (v >= CoordMin) && (v <= CoordMax);
  endfunction

  function automatic outcome_t transform_rect(input rect_t r);
    outcome_t o;
    longint   s, px, py, sw, sh, ox, oy, ow, oh;
    longint   cx, cy, cw, ch, right, bottom, lw;
    o  = '0;
    s  = longint'(scale_r);
    if (s == 0 || view_w_r == '0 || view_h_r == '0) return o;
    px = longint'($signed(r.pos_x)) * s + longint'($signed(origin_x_r));
    py = longint'($signed(r.pos_y)) * s + longint'($signed(origin_y_r));
    sw = longint'($signed(r.size_w)) * s;
    sh = longint'($signed(r.size_h)) * s;
    if (!in_coord_range(px) || !in_coord_range(py) ||
        !in_coord_range(sw) || !in_coord_range(sh)) return o;
    lw = longint'(r.stroke);
    if (lw > 0) begin
      if (lw * s > longint'(StrokeMax)) o.stroke = StrokeMax;
      else o.stroke = 8'(lw * s);
    end
    cx = longint'($signed(view_x_r));
    cy = longint'($signed(view_y_r));
    cw = longint'(view_w_r);
    ch = longint'(view_h_r);
    if ($signed(r.clip_w) > 0 && $signed(r.clip_h) > 0) begin
      right  = cx + cw;
      bottom = cy + ch;
      ox = longint'($signed(r.clip_x)) * s + longint'($signed(origin_x_r));
      oy = longint'($signed(r.clip_y)) * s + longint'($signed(origin_y_r));
      ow = longint'($signed(r.clip_w)) * s;
      oh = longint'($signed(r.clip_h)) * s;
      if (!in_coord_range(ox) || !in_coord_range(oy) ||
          !in_coord_range(ow) || !in_coord_range(oh)) return '0;
      if (ox > cx) cx = ox;
      if (oy > cy) cy = oy;
      if (ox + ow < right) right = ox + ow;
      if (oy + oh < bottom) bottom = oy + oh;
      cw = right - cx;
      ch = bottom - cy;
    end
    if (cw <= 0 || ch <= 0) return '0;
    o.ok     = 1'b1;
    o.pos_x  = px[31:0];
    o.pos_y  = py[31:0];
    o.size_w = sw[31:0];
    o.size_h = sh[31:0];
    o.clip_x = cx[31:0];
    o.clip_y = cy[31:0];
    o.clip_w = cw[31:0];
    o.clip_h = ch[31:0];
    return o;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_outcome(input outcome_t got);
    outcome_t want;
    if (pending_outcomes.size() == 0) begin
      $error("output transfer with no prediction waiting");
      fail_cnt++;
      return;
    end
    want = pending_outcomes.pop_front();
    compare_field("ok",         32'(want.ok),     32'(got.ok));
    compare_field("out_pos_x",  want.pos_x,       got.pos_x);
    compare_field("out_pos_y",  want.pos_y,       got.pos_y);
    compare_field("out_size_w", want.size_w,      got.size_w);
    compare_field("out_size_h", want.size_h,      got.size_h);
    compare_field("out_stroke", 32'(want.stroke), 32'(got.stroke));
    compare_field("out_clip_x", want.clip_x,      got.clip_x);
    compare_field("out_clip_y", want.clip_y,      got.clip_y);
    compare_field("out_clip_w", want.clip_w,      got.clip_w);
    compare_field("out_clip_h", want.clip_h,      got.clip_h);
  endtask

  // output side: check transfers, random idling and long stalls on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        check_outcome(outcome_t'({m_axis_tuser, m_axis_tdata}));
      if (rx_stall_req > 0) begin
        hold_left    = rx_stall_req;
        rx_stall_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(rx_idle_en && $urandom_range(99) < 37);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_rect(input rect_t r);
    while (tx_idle_en && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_outcomes.push_back(transform_rect(r));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // writes every register, then an unused index that must be ignored
  task automatic load_config(input logic [15:0] scale, input logic [31:0] org_x,
                             input logic [31:0] org_y, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [30:0] vw,
                             input logic [30:0] vh);
    logic [CfgAddrW-1:0] idx[8];
    logic [31:0]         val[8];
    idx = '{RegScale, RegOriginH, RegOriginV, RegViewL, RegViewT, RegViewW,
            RegViewH, RegUnused};
    val[0] = {16'($urandom), scale};
    val[1] = org_x;
    val[2] = org_y;
    val[3] = vx;
    val[4] = vy;
    val[5] = {1'($urandom), vw};
    val[6] = {1'($urandom), vh};
    val[7] = $urandom;
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    scale_r    = scale;
    origin_x_r = org_x;
    origin_y_r = org_y;
    view_x_r   = vx;
    view_y_r   = vy;
    view_w_r   = vw;
    view_h_r   = vh;
  endtask

  function automatic rect_t make_rect(input logic [31:0] px, input logic [31:0] py,
                                     input logic [31:0] sw, input logic [31:0] sh,
                                     input logic [7:0] st, input logic [31:0] cx,
                                     input logic [31:0] cy, input logic [31:0] cw,
                                     input logic [31:0] ch);
    rect_t r;
    r.pos_x  = px;
    r.pos_y  = py;
    r.size_w = sw;
    r.size_h = sh;
    r.stroke = st;
    r.clip_x = cx;
    r.clip_y = cy;
    r.clip_w = cw;
    r.clip_h = ch;
    return r;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel < 16) return 32'($urandom_range(2000)) - 32'd1000;
    case (sel)
      16:      return 32'($urandom_range(1 << 21)) - 32'd1048576;
      17:      return $urandom;
      18:      return pick_extreme();
      default: return 32'($urandom_range(80000)) - 32'd40000;
    endcase
  endfunction

  function automatic logic [31:0] rand_extent();
    case ($urandom_range(9))
      6:       return 32'd0;
      7:       return 32'd0 - 32'($urandom_range(1, 1000));
      8:       return $urandom;
      9:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(9))
      8:       return $urandom;
      9:       return pick_extreme();
      default: return 32'($urandom_range(8000)) - 32'd4000;
    endcase
  endfunction

  function automatic logic [30:0] rand_span();
    case ($urandom_range(24))
      0:       return '0;
      1, 2:    return 31'h7FFF_FFFF;
      3, 4:    return 31'($urandom);
      default: return 31'($urandom_range(1, 8000));
    endcase
  endfunction

  function automatic rect_t rand_rect();
    logic [7:0] st;
    case ($urandom_range(7))
      0:       st = 8'd0;
      1:       st = 8'd255;
      2:       st = 8'd1;
      default: st = 8'($urandom);
    endcase
    return make_rect(rand_coord(), rand_coord(), rand_coord(), rand_coord(), st,
                     rand_coord(), rand_coord(), rand_extent(), rand_extent());
  endfunction

  task automatic randomize_config();
    logic [15:0] scale;
    case ($urandom_range(9))
      0:          scale = $urandom_range(1) ? 16'd0 : 16'd1;
      1, 2, 3:    scale = 16'd1;
      4, 5, 6:    scale = 16'($urandom_range(2, 8));
      7:          scale = 16'($urandom_range(9, 300));
      8:          scale = 16'hFFFF;
      default:    scale = 16'($urandom);
    endcase
    load_config(scale, rand_offset(), rand_offset(), rand_offset(), rand_offset(),
                rand_span(), rand_span());
  endtask

  task automatic test_reset_state();
    // registers still at reset: the view is empty, so every item fails
    scale_r    = 16'd1;
    origin_x_r = '0;
    origin_y_r = '0;
    view_x_r   = '0;
    view_y_r   = '0;
    view_w_r   = '0;
    view_h_r   = '0;
    repeat (3) send_rect(rand_rect());
    wait_drained();
  endtask

  task automatic test_directed();
    load_config(16'd1, '0, '0, -32'sd100, -32'sd100, 31'd200, 31'd200);
    send_rect(make_rect(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        8'd255, 0, 0, 0, 5));
    send_rect(make_rect(1, 2, 3, 4, 8'd0, 10, 10, 20, 30));
    send_rect(make_rect(0, 0, 1, 1, 8'd7, 500, 500, 10, 10));
    send_rect(make_rect(-5, -5, 1, 1, 8'd1, 0, 0, 32'hFFFF_FFFF, 10));
    send_rect(make_rect(0, 0, 0, 0, 8'd128, 0, 0, 10, 32'h8000_0000));
    send_rect(make_rect(0, 0, 0, 0, 8'd2, -1000, -1000, 5000, 5000));
    send_rect(make_rect(0, 0, 0, 0, 8'd3, 100, 0, 10, 10));
    wait_drained();

    // largest scale with the widest view
    load_config(16'hFFFF, '0, '0, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                31'h7FFF_FFFF);
    send_rect(make_rect(1, -1, 1, -1, 8'd1, 0, 0, 0, 0));
    send_rect(make_rect(32768, -32768, 0, 0, 8'd0, 0, 0, 0, 0));
    send_rect(make_rect(32769, 0, 0, 0, 8'd1, 0, 0, 0, 0));
    send_rect(make_rect(0, 0, -32769, 0, 8'd1, 0, 0, 0, 0));
    send_rect(make_rect(0, 0, 0, 0, 8'd4, 32769, 0, 1, 1));
    send_rect(make_rect(0, 0, 0, 0, 8'd4, -10, -10, 20, 20));
    wait_drained();

    // origins at the limits, edges summing past 32 bits
    load_config(16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_rect(make_rect(0, 0, 5, 5, 8'd9, 0, 0, 0, 0));
    send_rect(make_rect(1, 0, 5, 5, 8'd9, 0, 0, 0, 0));
    send_rect(make_rect(0, -1, 5, 5, 8'd9, 0, 0, 0, 0));
    send_rect(make_rect(0, 0, 5, 5, 8'd9, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF));
    wait_drained();

    // zero scale, then empty view height
    load_config(16'd0, '0, '0, '0, '0, 31'd100, 31'd100);
    send_rect(make_rect(1, 1, 1, 1, 8'd1, 0, 0, 0, 0));
    wait_drained();
    load_config(16'd1, '0, '0, '0, '0, 31'd100, 31'd0);
    send_rect(make_rect(1, 1, 1, 1, 8'd1, 0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 20; p++) begin
      randomize_config();
      repeat (50) send_rect(rand_rect());
      wait_drained();
    end
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    load_config(16'd3, 32'd17, -32'sd250, -32'sd2000, -32'sd1500, 31'd6000,
                31'd5000);
    repeat (200) send_rect(rand_rect());
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_stall();
    randomize_config();
    tx_idle_en   = 1'b0;
    rx_stall_req = 150;
    repeat (60) send_rect(rand_rect());
    tx_idle_en = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random_configs();
    test_full_rate();
    test_output_stall();
    wait_drained();
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
